FILE: rtl/itoa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itoa_pkg: shared types and constants for int_to_ascii_digits
// Word width, digit register sizing, format codes, character codes, the
// sequencer state type and the control bundle of the digit datapath.
// ----------------------------------------------------------------------------
package itoa_pkg;

  // Input word width
  localparam int VALUE_WIDTH = 32;

  // Decimal digits needed for an unsigned word of VALUE_WIDTH bits
  // (log10(2) ~ 0.30103); also covers the hex digits of the word
  localparam int NUM_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int DIGIT_BITS = 4 * NUM_DIGITS;
  localparam int BIT_CNT_W  = $clog2(VALUE_WIDTH + 1);
  localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

  localparam int FMT_W  = 2;
  localparam int CHAR_W = 7;

  // Format codes; any other code converts as unsigned decimal
  localparam logic [FMT_W-1:0] FMT_SIGNED_DEC = 2'd0;
  localparam logic [FMT_W-1:0] FMT_HEX        = 2'd1;

  // Character codes
  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS   = 7'h2d;
  localparam logic [CHAR_W-1:0] CHAR_A_LOWER = 7'h61;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_SKIP,
    S_EMIT
  } state_e;

  // Control bundle from the sequencer to the digit datapath
  typedef struct packed {
    logic load;
    logic dabble;
    logic shift_digit;
  } bcd_ctrl_t;

  // Map one digit to its ASCII character
  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
    if (d < 4'd10) begin
      return CHAR_ZERO + {3'b000, d};
    end else begin
      return CHAR_A_LOWER + {3'b000, d - 4'd10};
    end
  endfunction

  // Double-dabble correction of one BCD digit
  function automatic logic [3:0] add3(input logic [3:0] d);
    return (d >= 4'd5) ? d + 4'd3 : d;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/int_to_ascii_digits.sv
`default_nettype none
// ----------------------------------------------------------------------------
// int_to_ascii_digits: binary word to ASCII text
// Converts one word per beat to signed decimal, lowercase hex or unsigned
// decimal text, one character per output beat, most significant first.
// ----------------------------------------------------------------------------
// One word is handled at a time. A decimal word passes through the
// bit-serial double-dabble shift register, one input bit per cycle; a hex
// word skips that step. Leading zero digits are then dropped one per cycle,
// the sequencer moves on to emission, and the characters leave one per cycle
// while the output is not stalled. A negative signed word gives a leading
// '-', sent ahead of the digits as soon as the output slot is free. The last
// character carries last_o; the next word is accepted once that character is
// in the output register.
module int_to_ascii_digits (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [itoa_pkg::VALUE_WIDTH-1:0] value_i,
  input  wire logic [itoa_pkg::FMT_W-1:0]       format_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [itoa_pkg::CHAR_W-1:0]           char_code_o,
  output logic                                  last_o
);
  import itoa_pkg::*;

  state_e                 state_q, state_d;
  logic                   minus_q, minus_d;
  logic                   hex_q, hex_d;
  logic [BIT_CNT_W-1:0]   cnt_q, cnt_d;
  logic [DIG_CNT_W-1:0]   rem_q, rem_d;
  logic                   out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]      char_q;
  logic                   last_q;

  logic                   accept;
  logic                   slot_free;
  logic                   neg;
  logic [VALUE_WIDTH-1:0] mag;
  logic [3:0]             top_digit;
  bcd_ctrl_t              ctrl;
  logic                   push;
  logic [CHAR_W-1:0]      push_char;
  logic                   push_last;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;

  // Take the magnitude of a negative signed word
  assign neg = (format_i == FMT_SIGNED_DEC) && value_i[VALUE_WIDTH-1];
  assign mag = neg ? (~value_i + 1'b1) : value_i;

  itoa_bcd u_bcd (
    .clk_i        (clk_i),
    .ctrl_i       (ctrl),
    .load_hex_i   (format_i == FMT_HEX),
    .load_value_i (mag),
    .top_digit_o  (top_digit)
  );

  // Sequence load, conversion, zero skip and character emission
  always_comb begin
    state_d   = state_q;
    minus_d   = minus_q;
    hex_d     = hex_q;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    ctrl      = '0;
    push      = 1'b0;
    push_char = digit_char(top_digit);
    push_last = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          ctrl.load = 1'b1;
          minus_d   = neg;
          hex_d     = (format_i == FMT_HEX);
          cnt_d     = BIT_CNT_W'(VALUE_WIDTH);
          rem_d     = DIG_CNT_W'(NUM_DIGITS);
          state_d   = (format_i == FMT_HEX) ? S_SKIP : S_CONV;
        end
      end
      S_CONV: begin
        ctrl.dabble = 1'b1;
        cnt_d       = cnt_q - 1'b1;
        if (cnt_q == BIT_CNT_W'(1)) begin
          state_d = S_SKIP;
        end
      end
      S_SKIP: begin
        if (top_digit == 4'd0 && rem_q != DIG_CNT_W'(1)) begin
          ctrl.shift_digit = 1'b1;
          rem_d            = rem_q - 1'b1;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free && !minus_q) begin
          push             = 1'b1;
          push_last        = (rem_q == DIG_CNT_W'(1));
          ctrl.shift_digit = 1'b1;
          rem_d            = rem_q - 1'b1;
          if (rem_q == DIG_CNT_W'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    // Send the minus sign ahead of the digits
    if (minus_q && slot_free) begin
      push      = 1'b1;
      push_char = CHAR_MINUS;
      push_last = 1'b0;
      minus_d   = 1'b0;
    end
  end

  // Hold the output beat until it is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (push) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      minus_q     <= 1'b0;
      hex_q       <= 1'b0;
      cnt_q       <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      minus_q     <= minus_d;
      hex_q       <= hex_d;
      cnt_q       <= cnt_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      char_q <= push_char;
      last_q <= push_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign last_o      = last_q;

  // The sign has always left by the time the block is idle again
  a_minus_gone_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !minus_q)
    else $error("minus sign still pending in idle");

  // Hex words never go through the double dabble
  a_hex_no_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CONV |-> !hex_q)
    else $error("hex word in conversion");

  // Digits remain while emitting
  a_emit_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT |-> rem_q != '0)
    else $error("emit with no digits left");

  // The last character ends the word
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && push_last |=> state_q == S_IDLE && out_valid_q && last_q)
    else $error("last character did not end the word");

endmodule
`default_nettype wire

FILE: rtl/itoa_bcd.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itoa_bcd: bit-serial binary to digit shift register
// Holds the binary word and a register of 4-bit digits. In decimal mode one
// binary bit enters the BCD digits per cycle (double dabble); in hex mode the
// word is loaded straight into the digits. Digits leave from the top, one per
// shift.
// ----------------------------------------------------------------------------
module itoa_bcd (
  input  wire logic                          clk_i,
  input  wire itoa_pkg::bcd_ctrl_t           ctrl_i,
  input  wire logic                          load_hex_i,
  input  wire logic [itoa_pkg::VALUE_WIDTH-1:0] load_value_i,
  output logic [3:0]                         top_digit_o
);
  import itoa_pkg::*;

  logic [VALUE_WIDTH-1:0] bin_q, bin_d;
  logic [DIGIT_BITS-1:0]  dig_q, dig_d;
  logic [DIGIT_BITS-1:0]  dig_adj;

  // Correct every digit before the next doubling
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      dig_adj[4*i +: 4] = add3(dig_q[4*i +: 4]);
    end
  end

  // Load, dabble or shift out a digit
  always_comb begin
    bin_d = bin_q;
    dig_d = dig_q;
    if (ctrl_i.load) begin
      bin_d = load_value_i;
      dig_d = load_hex_i ? {{(DIGIT_BITS - VALUE_WIDTH){1'b0}}, load_value_i}
                         : '0;
    end else if (ctrl_i.dabble) begin
      bin_d = {bin_q[VALUE_WIDTH-2:0], 1'b0};
      dig_d = {dig_adj[DIGIT_BITS-2:0], bin_q[VALUE_WIDTH-1]};
    end else if (ctrl_i.shift_digit) begin
      dig_d = {dig_q[DIGIT_BITS-5:0], 4'b0000};
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    dig_q <= dig_d;
  end

  assign top_digit_o = dig_q[DIGIT_BITS-1 -: 4];

endmodule
`default_nettype wire

FILE: verif/int_to_ascii_digits_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// int_to_ascii_digits_tb: self-checking bench for the word-to-text converter
// Feeds words in signed decimal, hex, unsigned decimal and the spare format,
// spells each accepted word into the expected characters and compares every
// output beat against them, under several sender and receiver idle mixes.
// ----------------------------------------------------------------------------
module int_to_ascii_digits_tb;
  import itoa_pkg::*;

  // Format codes the package leaves unnamed
  localparam logic [FMT_W-1:0] FMT_UNSIGNED_DEC = 2'd2;
  localparam logic [FMT_W-1:0] FMT_SPARE        = 2'd3;

  // ASCII codes of the expected text
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'h2d;
  localparam logic [CHAR_W-1:0] ASCII_A     = 7'h61;

  localparam int MAX_SHOWN = 10;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] word;
    logic [FMT_W-1:0]       fmt;
  } word_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_beat_t;

  logic                   clk_i     = 1'b0;
  logic                   rst_ni    = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  logic [VALUE_WIDTH-1:0] value     = '0;
  logic [FMT_W-1:0]       fmt       = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [CHAR_W-1:0]      char_code;
  logic                   last;

  word_item_t pending_words[$];
  text_beat_t expected_text[$];
  int         send_idle_pct  = 0;
  int         recv_stall_pct = 0;
  int         fail_count     = 0;

  int_to_ascii_digits dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .value_i     (value),
    .format_i    (fmt),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .char_code_o (char_code),
    .last_o      (last)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Spell one word into the characters the block must emit
  task automatic spell_word(input logic [VALUE_WIDTH-1:0] word, input logic [FMT_W-1:0] f);
    logic [VALUE_WIDTH-1:0] mag;
    int unsigned            radix;
    int unsigned            digits[$];
    text_beat_t             beat;
    mag   = word;
    radix = (f == FMT_HEX) ? 16 : 10;
    // Negative signed word: minus sign, then the magnitude
    if (f == FMT_SIGNED_DEC && word[VALUE_WIDTH-1]) begin
      beat.code = ASCII_MINUS;
      beat.last = 1'b0;
      expected_text.push_back(beat);
      mag = -word;
    end
    // Collect digits least significant first; zero still gives one digit
    do begin
      digits.push_front(int'(mag % radix));
      mag = mag / radix;
    end while (mag != 0);
    foreach (digits[i]) begin
      beat.code = (digits[i] < 10) ? ASCII_ZERO + CHAR_W'(digits[i])
                                   : ASCII_A + CHAR_W'(digits[i] - 10);
      beat.last = (i == digits.size() - 1);
      expected_text.push_back(beat);
    end
  endtask

  task automatic queue_word(input logic [VALUE_WIDTH-1:0] w, input logic [FMT_W-1:0] f);
    word_item_t item;
    item.word = w;
    item.fmt  = f;
    pending_words.push_back(item);
  endtask

  // Mix of full-range, short, near-power-of-ten and small negative words
  task automatic queue_random_words(input int n);
    logic [VALUE_WIDTH-1:0] w;
    logic [VALUE_WIDTH-1:0] p;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 4))
        0: w = VALUE_WIDTH'({$urandom(), $urandom()});
        1: w = VALUE_WIDTH'($urandom_range(0, 20));
        2: w = VALUE_WIDTH'($urandom() >> $urandom_range(0, 31));
        3: w = '0 - VALUE_WIDTH'($urandom_range(1, 1000));
        default: begin
          p = 1;
          repeat ($urandom_range(0, 9)) p = p * 10;
          w = p + VALUE_WIDTH'($urandom_range(0, 2)) - 1;
        end
      endcase
      queue_word(w, FMT_W'($urandom_range(0, 3)));
    end
  endtask

  task automatic wait_words_sent();
    while (pending_words.size() != 0 || in_valid) @(posedge clk_i);
  endtask

  // Driver: hold a stalled beat, otherwise present the next word or idle
  always @(posedge clk_i) begin : drive_words
    word_item_t item;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        spell_word(value, fmt);
      end
      if (!in_valid || !in_stall) begin
        if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          item = pending_words.pop_front();
          in_valid <= 1'b1;
          value    <= item.word;
          fmt      <= item.fmt;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted character beat, then pick the next stall
  always @(posedge clk_i) begin : check_text
    text_beat_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_text.size() == 0) begin
        if (fail_count < MAX_SHOWN) begin
          $display("unexpected beat: char 0x%02h last %0b", char_code, last);
        end
        fail_count++;
      end else begin
        want = expected_text.pop_front();
        if (char_code !== want.code || last !== want.last) begin
          if (fail_count < MAX_SHOWN) begin
            $display("mismatch: char exp 0x%02h got 0x%02h, last exp %0b got %0b",
                     want.code, char_code, want.last, last);
          end
          fail_count++;
        end
      end
    end
    out_stall <= rst_ni && ($urandom_range(0, 99) < recv_stall_pct);
  end

  initial begin : run_phases
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: zero and all-ones in every format, then extremes and digit boundaries
    queue_word('0, FMT_SIGNED_DEC);
    queue_word('0, FMT_HEX);
    queue_word('0, FMT_UNSIGNED_DEC);
    queue_word('0, FMT_SPARE);
    queue_word('1, FMT_SIGNED_DEC);
    queue_word('1, FMT_HEX);
    queue_word('1, FMT_UNSIGNED_DEC);
    queue_word('1, FMT_SPARE);
    queue_word({1'b1, {(VALUE_WIDTH-1){1'b0}}}, FMT_SIGNED_DEC);
    queue_word({1'b1, {(VALUE_WIDTH-1){1'b0}}}, FMT_HEX);
    queue_word({1'b1, {(VALUE_WIDTH-1){1'b0}}}, FMT_UNSIGNED_DEC);
    queue_word({1'b0, {(VALUE_WIDTH-1){1'b1}}}, FMT_SIGNED_DEC);
    queue_word({1'b0, {(VALUE_WIDTH-1){1'b1}}}, FMT_UNSIGNED_DEC);
    queue_word(1, FMT_SIGNED_DEC);
    queue_word(9, FMT_UNSIGNED_DEC);
    queue_word(10, FMT_SIGNED_DEC);
    queue_word(10, FMT_HEX);
    queue_word(15, FMT_HEX);
    queue_word(16, FMT_HEX);
    queue_word(999999999, FMT_UNSIGNED_DEC);
    queue_word(1000000000, FMT_SIGNED_DEC);
    queue_word(32'hdeadbeef, FMT_HEX);
    queue_word(32'h5a5a5a5a, FMT_SPARE);
    queue_random_words(50);
    wait_words_sent();

    // Sender idles often
    send_idle_pct  = 60;
    recv_stall_pct = 0;
    queue_random_words(50);
    wait_words_sent();

    // Receiver stalls often
    send_idle_pct  = 0;
    recv_stall_pct = 60;
    queue_random_words(50);
    wait_words_sent();

    // Light idling on both sides
    send_idle_pct  = 13;
    recv_stall_pct = 13;
    queue_random_words(50);
    wait_words_sent();

    // Drain the text, then watch for stray beats
    while (expected_text.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    if (fail_count == 0 && expected_text.size() == 0) begin
      $display("** int_to_ascii_digits: PASSED **");
    end else begin
      $display("** int_to_ascii_digits: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #1000000;
    $display("** int_to_ascii_digits: FAILED **");
    $finish;
  end

endmodule
`default_nettype wire
